// ===== rtl/bba_pkg.sv =====
// shared codes and field widths of the buddy block allocator
package bba_pkg;

	localparam int OP_W    = 1;
	localparam int ORDER_W = 4;
	localparam int BLOCK_W = 10;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_ORDER = 2'd2
	} status_t;

endpackage

// ===== rtl/bba_if.sv =====
// request and response channels of the buddy block allocator
interface bba_req_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ORDER_W-1:0] order;
	logic [BLOCK_W-1:0] block_index;

	modport source (output valid, operation, order, block_index, input ready);
	modport sink   (input valid, operation, order, block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [BLOCK_W-1:0] placed_block;
	logic [ORDER_W-1:0] largest_free_order;

	modport source (output valid, status, placed_block, largest_free_order, input ready);
	modport sink   (input valid, status, placed_block, largest_free_order, output ready);
endinterface

// ===== rtl/buddy_block_allocator.sv =====
// Buddy allocator over 2^(TREE_LEVELS-1) blocks. The tree lives in one node memory (one write
// port, one read port, registered read), one entry per node holding both children's
// largest free order and wholly-free flags. After reset a clearing pass writes every node
// before the first request is taken. A request is handled one at a time: an allocate of
// order k walks down the tree one level per cycle and then rewrites the ancestors one level
// per cycle; a free only does the upward rewrite. Each request is accepted in the idle
// state and its response is handed over from the done state, which waits while the output
// register holds a response not yet taken. The rate is set by the memory read latency on
// each tree level. The response sits in an output register, so the next request may be
// accepted while a response waits.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int TREE_LEVELS = 11
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);

	localparam int NODES = 2 ** (TREE_LEVELS - 1);
	localparam int BW    = TREE_LEVELS - 1;              // node address bits
	localparam int NW    = TREE_LEVELS;                  // node number incl. leaf level
	localparam int OW    = $clog2(TREE_LEVELS + 1);      // stored order bits
	localparam int CW    = (OW > ORDER_W) ? OW : ORDER_W;
	localparam int PW    = (BW > BLOCK_W) ? BW : BLOCK_W;

	typedef struct packed {
		logic [OW-1:0] lo;
		logic [OW-1:0] ro;
		logic          lw;
		logic          rw;
	} node_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DESC  = 5'b00100,
		S_UPD   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// node memory
	node_t         mem [NODES];
	node_t         mem_rdata;
	node_t         mem_wdata;
	logic [BW-1:0] mem_raddr;
	logic [BW-1:0] mem_waddr;
	logic          mem_we;

	// control
	state_t        state_q, state_d;
	logic [BW-1:0] clr_q, clr_d;
	logic [OW-1:0] clr_ord_q, clr_ord_d;
	logic [OW-1:0] lfo_q, lfo_d;
	logic          out_valid_q, out_valid_d;

	// request payload
	logic [OW-1:0] ord_q, ord_d;
	logic [OW-1:0] lvl_q, lvl_d;
	logic [NW-1:0] next_q, next_d;
	logic [NW-1:0] node_q, node_d;
	logic [OW-1:0] fs_q, fs_d;
	logic          whole_q, whole_d;
	status_t       status_q, status_d;
	logic [BW-1:0] placed_q, placed_d;

	// response register
	status_t            rsp_status_q;
	logic [BLOCK_W-1:0] rsp_placed_q;
	logic [ORDER_W-1:0] rsp_lfo_q;
	logic               rsp_load;

	// combinational helpers
	logic [CW-1:0]      ord_in_w;
	logic [CW-1:0]      lfo_w;
	logic [PW-1:0]      blk_w;
	logic [PW-1:0]      placed_w;
	logic [NW-1:0]      free_start;
	logic               go_right;
	logic [NW-1:0]      next_new;
	logic [OW-1:0]      lvl_dec;
	logic [NW-1:0]      shl;
	logic [BW-1:0]      parent;
	node_t              upd;
	logic               both;
	logic [OW-1:0]      fs_new;

	assign ord_in_w   = CW'(req.order);
	assign lfo_w      = CW'(lfo_q);
	assign blk_w      = PW'(req.block_index);
	assign free_start = {1'b1, blk_w[BW-1:0]} >> (req.order - ORDER_W'(1));

	// descent: best fit among the children of the node just read
	always_comb begin
		if (mem_rdata.lo < ord_q) begin
			go_right = 1'b1;
		end else if (mem_rdata.ro < ord_q) begin
			go_right = 1'b0;
		end else begin
			go_right = (mem_rdata.lo > mem_rdata.ro);
		end
	end
	assign next_new = {next_q[NW-2:0], go_right};
	assign lvl_dec  = lvl_q - OW'(1);
	// leaf node shifted up to the block grid, top marker bit dropped
	assign shl      = next_new << (ord_q - OW'(1));

	// upward rewrite of the parent of node_q
	assign parent = BW'(node_q >> 1);
	always_comb begin
		upd = mem_rdata;
		if (node_q[0]) begin
			upd.ro = fs_q;
			upd.rw = whole_q;
		end else begin
			upd.lo = fs_q;
			upd.lw = whole_q;
		end
		both = upd.lw & upd.rw;
		if (upd.lo == upd.ro) begin
			fs_new = both ? upd.lo + OW'(1) : upd.lo;
		end else begin
			fs_new = (upd.lo > upd.ro) ? upd.lo : upd.ro;
		end
	end

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		clr_ord_d   = clr_ord_q;
		lfo_d       = lfo_q;
		out_valid_d = out_valid_q;
		ord_d       = ord_q;
		lvl_d       = lvl_q;
		next_d      = next_q;
		node_d      = node_q;
		fs_d        = fs_q;
		whole_d     = whole_q;
		status_d    = status_q;
		placed_d    = placed_q;
		mem_raddr   = '0;
		mem_waddr   = parent;
		mem_wdata   = upd;
		mem_we      = 1'b0;
		rsp_load    = 1'b0;

		if (out_valid_q && rsp.ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == '0) begin
					mem_wdata = '{lo: '0, ro: OW'(TREE_LEVELS), lw: 1'b0, rw: 1'b1};
				end else begin
					mem_wdata = '{lo: clr_ord_q, ro: clr_ord_q, lw: 1'b1, rw: 1'b1};
					// last node of a tree level
					if ((clr_q & (clr_q + BW'(1))) == '0) begin
						clr_ord_d = clr_ord_q - OW'(1);
					end
				end
				clr_d = clr_q + BW'(1);
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					ord_d    = OW'(req.order);
					status_d = ST_DONE;
					placed_d = '0;
					if (req.order == '0) begin
						status_d = ST_BAD_ORDER;
						state_d  = S_DONE;
					end else if (req.operation == OP_ALLOC) begin
						if (lfo_w < ord_in_w) begin
							status_d = ST_NO_SPACE;
							state_d  = S_DONE;
						end else if (ord_in_w == CW'(TREE_LEVELS)) begin
							node_d    = NW'(1);
							fs_d      = '0;
							whole_d   = 1'b0;
							mem_raddr = '0;
							state_d   = S_UPD;
						end else begin
							next_d    = NW'(1);
							lvl_d     = OW'(TREE_LEVELS);
							mem_raddr = BW'(1);
							state_d   = S_DESC;
						end
					end else begin
						if (ord_in_w > CW'(TREE_LEVELS)) begin
							status_d = ST_BAD_ORDER;
							state_d  = S_DONE;
						end else begin
							node_d    = free_start;
							fs_d      = OW'(req.order);
							whole_d   = 1'b1;
							mem_raddr = BW'(free_start >> 1);
							state_d   = S_UPD;
						end
					end
				end
			end
			S_DESC: begin
				next_d = next_new;
				lvl_d  = lvl_dec;
				if (lvl_dec > ord_q) begin
					mem_raddr = next_new[BW-1:0];
				end else begin
					placed_d  = shl[BW-1:0];
					node_d    = next_new;
					fs_d      = '0;
					whole_d   = 1'b0;
					mem_raddr = next_q[BW-1:0];
					state_d   = S_UPD;
				end
			end
			S_UPD: begin
				mem_we = 1'b1;
				if (parent == '0) begin
					lfo_d   = upd.ro;
					state_d = S_DONE;
				end else begin
					node_d    = NW'(parent);
					fs_d      = fs_new;
					whole_d   = both;
					mem_raddr = BW'(node_q >> 2);
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					rsp_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_ord_q   <= OW'(TREE_LEVELS - 1);
			lfo_q       <= OW'(TREE_LEVELS);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			clr_ord_q   <= clr_ord_d;
			lfo_q       <= lfo_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign placed_w = PW'(placed_q);

	always_ff @(posedge clk) begin
		ord_q    <= ord_d;
		lvl_q    <= lvl_d;
		next_q   <= next_d;
		node_q   <= node_d;
		fs_q     <= fs_d;
		whole_q  <= whole_d;
		status_q <= status_d;
		placed_q <= placed_d;
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_placed_q <= placed_w[BLOCK_W-1:0];
			rsp_lfo_q    <= lfo_w[ORDER_W-1:0];
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = rsp_status_q;
	assign rsp.placed_block       = rsp_placed_q;
	assign rsp.largest_free_order = rsp_lfo_q;

	// the whole-memory free order never exceeds the tree height
	assert property (@(posedge clk) disable iff (!arst_n)
		lfo_q <= OW'(TREE_LEVELS))
		else $error("largest free order out of range");

	// the upward rewrite never starts from the sentinel node
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> node_q != '0)
		else $error("rewrite reached sentinel as child");

	// the descent only runs above the requested order and never writes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DESC |-> (lvl_q > ord_q) && !mem_we)
		else $error("descent past requested order");

	// a failed request carries no placement
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp.status == ST_DONE || rsp.placed_block == '0)
		else $error("placement on failed request");

endmodule
